// ----- hw/rtl/voxel_ray_traversal_assert.svh -----
// Assertion macros shared by the voxel ray traversal RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef VOXEL_RAY_TRAVERSAL_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_ASSERT_SVH

// Clocked check, off while reset is applied.
`define VRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define VRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/vrt_pkg.sv -----
// Package for the voxel ray traversal block: constants, state codes,
// and the command and status structs between controller and datapath.
package vrt_pkg;

  localparam int FracBits = 11;
  localparam int GridSize = 32;
  localparam int DistW    = FracBits + 10;
  localparam int QuotW    = FracBits + 15;
  localparam int QCntW    = $clog2(QuotW);
  localparam int AddrW    = 10;
  localparam int WordW    = 32;
  localparam int MemDepth = 1024;
  localparam logic [DistW-1:0] DistLimit  = {DistW{1'b1}};
  localparam logic [15:0]      ReachReset = 16'd16384;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV, S_MUL, S_STEP, S_CHECK, S_DONE
  } state_e;

  typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_e;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic div_step;
    logic mul;
    logic step;
    logic set_hit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_cast;
    logic div_done;
    logic axis_last;
    logic reach_ok;
    logic occ_hit;
    logic past_grid;
  } sts_t;

endpackage

// ----- hw/rtl/vrt_ctrl.sv -----
// Controller state machine of the voxel ray traversal block.
// Depends on vrt_pkg and voxel_ray_traversal_assert.svh.
`include "voxel_ray_traversal_assert.svh"
module vrt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  vrt_pkg::sts_t sts_i,
  output vrt_pkg::cmd_t cmd_o
);
  import vrt_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.is_cast ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = sts_i.axis_last ? S_STEP : S_DIV;
      end
      S_STEP: begin
        if (sts_i.reach_ok) begin
          cmd_o.step = 1'b1;
          state_d    = S_CHECK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CHECK: begin
        if (sts_i.occ_hit) begin
          cmd_o.set_hit = 1'b1;
          state_d       = S_DONE;
        end else if (sts_i.past_grid) begin
          state_d = S_DONE;
        end else begin
          state_d = S_STEP;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `VRT_ASSERT_ALWAYS(a_no_accept_in_clear, (state_q == S_CLEAR) |-> !in_ready_o, "ready during clear")
  `VRT_ASSERT(a_valid_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result not from done")
  `VRT_ASSERT(a_check_after_step, (state_q == S_CHECK) |-> $past(state_q == S_STEP), "check without step")
endmodule

// ----- hw/rtl/vrt_datapath.sv -----
// Datapath of the voxel ray traversal block: occupancy memory, shared
// reciprocal divider, side multiplier, DDA stepper and result registers.
// Depends on vrt_pkg.
module vrt_datapath #(
  parameter int GRID_SIZE = vrt_pkg::GridSize
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vrt_pkg::cmd_t              cmd_i,
  output vrt_pkg::sts_t              sts_o,
  input  logic                       cfg_we_i,
  input  logic [15:0]                cfg_wdata_i,
  input  logic                       operation_i,
  input  logic [vrt_pkg::AddrW-1:0]  word_addr_i,
  input  logic [vrt_pkg::WordW-1:0]  word_bits_i,
  input  logic [15:0]                origin_x_i,
  input  logic [15:0]                origin_y_i,
  input  logic [15:0]                origin_z_i,
  input  logic signed [15:0]         dir_x_i,
  input  logic signed [15:0]         dir_y_i,
  input  logic signed [15:0]         dir_z_i,
  output logic                       hit_o,
  output logic [4:0]                 voxel_x_o,
  output logic [4:0]                 voxel_y_o,
  output logic [4:0]                 voxel_z_o,
  output logic [1:0]                 face_axis_o,
  output logic                       face_negative_o,
  output logic [15:0]                hit_distance_o
);
  import vrt_pkg::*;

  localparam int CellW = (($clog2(GRID_SIZE) > 5) ? $clog2(GRID_SIZE) : 5) + 2;
  typedef logic signed [CellW-1:0] cell_t;
  localparam cell_t GridEnd = cell_t'(GRID_SIZE);

  logic [WordW-1:0] mem [MemDepth];
  logic [WordW-1:0] rdata_q;
  logic [4:0]       bitx_q;

  logic [15:0]       max_reach_q;
  logic [AddrW-1:0]  clr_cnt_q;
  logic [15:0]       org_q [3];
  logic [15:0]       dir_q [3];
  axis_e             axis_q;
  logic [15:0]       rem_q;
  logic [QuotW-1:0]  quo_q;
  logic [QCntW-1:0]  dcnt_q;
  logic [DistW-1:0]  delta_q [3];
  logic [DistW-1:0]  side_q [3];
  cell_t             cell_q [3];
  logic [DistW-1:0]  dist_q;
  axis_e             last_axis_q;
  logic              inside_q;
  logic              past_q;
  logic              hit_q;

  logic [15:0]             mag;
  logic                    dbit;
  logic [16:0]             trial;
  logic                    ge;
  logic [DistW-1:0]        delta_new;
  logic [FracBits:0]       mfac;
  logic [FracBits+DistW:0] prod;
  logic [DistW:0]          shifted;
  logic [DistW-1:0]        side_new;
  axis_e                   sel;
  cell_t                   cell_nxt [3];
  logic [DistW:0]          side_sum;
  logic                    inside_nxt;
  logic                    past_nxt;
  logic [AddrW-1:0]        raddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_reach_q <= ReachReset;
      clr_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) max_reach_q <= cfg_wdata_i;
      if (cmd_i.clr_en) clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      mem[clr_cnt_q] <= '0;
    end else if (cmd_i.load && operation_i == OP_WRITE) begin
      mem[word_addr_i] <= word_bits_i;
    end
    if (cmd_i.step) begin
      rdata_q <= mem[raddr];
    end
  end

  assign mag   = dir_q[axis_q][15] ? 16'(-dir_q[axis_q]) : dir_q[axis_q];
  assign dbit  = (dcnt_q == QCntW'(QuotW - 1));
  assign trial = {rem_q, dbit};
  assign ge    = (trial >= {1'b0, mag});

  assign delta_new = (mag == '0 || quo_q > QuotW'(DistLimit)) ? DistLimit
                                                               : quo_q[DistW-1:0];
  assign mfac = dir_q[axis_q][15] ? {1'b0, org_q[axis_q][FracBits-1:0]}
      : ((FracBits+1)'(1 << FracBits) - {1'b0, org_q[axis_q][FracBits-1:0]});
  assign prod     = mfac * delta_new;
  assign shifted  = prod[FracBits+DistW:FracBits];
  assign side_new = (shifted > (DistW+1)'(DistLimit)) ? DistLimit : shifted[DistW-1:0];

  always_comb begin
    if (side_q[0] < side_q[1] && side_q[0] < side_q[2]) begin
      sel = AXIS_X;
    end else if (side_q[1] < side_q[2]) begin
      sel = AXIS_Y;
    end else begin
      sel = AXIS_Z;
    end
    for (int a = 0; a < 3; a++) begin
      cell_nxt[a] = cell_q[a];
    end
    cell_nxt[sel] = dir_q[sel][15] ? cell_q[sel] - cell_t'(1) : cell_q[sel] + cell_t'(1);
    side_sum   = {1'b0, side_q[sel]} + {1'b0, delta_q[sel]};
    inside_nxt = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (cell_nxt[a] < cell_t'(0) || cell_nxt[a] >= GridEnd) inside_nxt = 1'b0;
    end
    past_nxt = dir_q[sel][15] ? (cell_nxt[sel] < cell_t'(0)) : (cell_nxt[sel] >= GridEnd);
    raddr    = {cell_nxt[2][4:0], cell_nxt[1][4:0]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      org_q[0]  <= origin_x_i;
      org_q[1]  <= origin_y_i;
      org_q[2]  <= origin_z_i;
      dir_q[0]  <= dir_x_i;
      dir_q[1]  <= dir_y_i;
      dir_q[2]  <= dir_z_i;
      cell_q[0] <= cell_t'(origin_x_i[15:FracBits]);
      cell_q[1] <= cell_t'(origin_y_i[15:FracBits]);
      cell_q[2] <= cell_t'(origin_z_i[15:FracBits]);
      dist_q    <= '0;
      axis_q    <= AXIS_X;
      rem_q     <= '0;
      quo_q     <= '0;
      dcnt_q    <= QCntW'(QuotW - 1);
      hit_q     <= 1'b0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= ge ? 16'(trial - {1'b0, mag}) : trial[15:0];
      quo_q  <= {quo_q[QuotW-2:0], ge};
      dcnt_q <= dcnt_q - 1'b1;
    end
    if (cmd_i.mul) begin
      delta_q[axis_q] <= delta_new;
      side_q[axis_q]  <= side_new;
      if (axis_q != AXIS_Z) begin
        axis_q <= axis_e'(axis_q + 2'd1);
        rem_q  <= '0;
        quo_q  <= '0;
        dcnt_q <= QCntW'(QuotW - 1);
      end
    end
    if (cmd_i.step) begin
      dist_q       <= side_q[sel];
      side_q[sel]  <= side_sum[DistW] ? DistLimit : side_sum[DistW-1:0];
      cell_q[sel]  <= cell_nxt[sel];
      last_axis_q  <= sel;
      inside_q     <= inside_nxt;
      past_q       <= past_nxt;
      bitx_q       <= cell_nxt[0][4:0];
    end
    if (cmd_i.set_hit) hit_q <= 1'b1;
    if (cmd_i.out_load) begin
      hit_o           <= hit_q;
      voxel_x_o       <= hit_q ? cell_q[0][4:0] : '0;
      voxel_y_o       <= hit_q ? cell_q[1][4:0] : '0;
      voxel_z_o       <= hit_q ? cell_q[2][4:0] : '0;
      face_axis_o     <= hit_q ? last_axis_q : AXIS_X;
      face_negative_o <= hit_q & ~dir_q[last_axis_q][15];
      hit_distance_o  <= !hit_q ? '0
                       : (dist_q > DistW'(16'hFFFF)) ? 16'hFFFF : dist_q[15:0];
    end
  end

  assign sts_o.clr_done  = (clr_cnt_q == {AddrW{1'b1}});
  assign sts_o.is_cast   = (operation_i == OP_CAST);
  assign sts_o.div_done  = (dcnt_q == '0);
  assign sts_o.axis_last = (axis_q == AXIS_Z);
  assign sts_o.reach_ok  = (dist_q < DistW'(max_reach_q));
  assign sts_o.occ_hit   = inside_q & rdata_q[bitx_q];
  assign sts_o.past_grid = past_q;
endmodule

// ----- hw/rtl/voxel_ray_traversal.sv -----
// Voxel ray traversal: 3D grid DDA over a 32x32x32 occupancy bitmap.
// After reset a clearing pass zeroes the 1024-word store; no input is taken meanwhile.
// A write item stores its word, then passes to the result register. A ray item uses one
// shared restoring divider once per axis, then steps voxel by voxel, each step a memory
// read and then a check. One item at a time; a finished result waits in the
// output register while the next item is taken.
module voxel_ray_traversal #(
  parameter int GRID_SIZE = vrt_pkg::GridSize
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [15:0]                cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       operation_i,
  input  logic [vrt_pkg::AddrW-1:0]  word_addr_i,
  input  logic [vrt_pkg::WordW-1:0]  word_bits_i,
  input  logic [15:0]                origin_x_i,
  input  logic [15:0]                origin_y_i,
  input  logic [15:0]                origin_z_i,
  input  logic signed [15:0]         dir_x_i,
  input  logic signed [15:0]         dir_y_i,
  input  logic signed [15:0]         dir_z_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       hit_o,
  output logic [4:0]                 voxel_x_o,
  output logic [4:0]                 voxel_y_o,
  output logic [4:0]                 voxel_z_o,
  output logic [1:0]                 face_axis_o,
  output logic                       face_negative_o,
  output logic [15:0]                hit_distance_o
);
  import vrt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vrt_datapath #(.GRID_SIZE(GRID_SIZE)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .operation_i     (operation_i),
    .word_addr_i     (word_addr_i),
    .word_bits_i     (word_bits_i),
    .origin_x_i      (origin_x_i),
    .origin_y_i      (origin_y_i),
    .origin_z_i      (origin_z_i),
    .dir_x_i         (dir_x_i),
    .dir_y_i         (dir_y_i),
    .dir_z_i         (dir_z_i),
    .hit_o           (hit_o),
    .voxel_x_o       (voxel_x_o),
    .voxel_y_o       (voxel_y_o),
    .voxel_z_o       (voxel_z_o),
    .face_axis_o     (face_axis_o),
    .face_negative_o (face_negative_o),
    .hit_distance_o  (hit_distance_o)
  );
endmodule
